// ===== hw/rtl/qvr_pkg.sv =====
`timescale 1ns / 1ps
// shared types, widths and helpers for the quaternion vector rotator
package qvr_pkg;

   // vector format and the split used by the dot-product multipliers
   localparam int VEC_WIDTH = 32;
   localparam int VL_W      = VEC_WIDTH / 2;
   localparam int VH_W      = VEC_WIDTH - VL_W;

   // quaternion format
   localparam int Q_W   = 32;
   localparam int QFRAC = 30;
   localparam int QP_W  = Q_W + 2;   // rounded quaternion product
   localparam int M_W   = QP_W + 2;  // rotation matrix entry

   // dot-product widths
   localparam int PH_W  = M_W + VH_W;
   localparam int PL_W  = M_W + VL_W + 1;
   localparam int HI_W  = PH_W + 2;
   localparam int LO_W  = PL_W + 2;
   localparam int ACC_W = M_W + VEC_WIDTH + 3;
   localparam int R_W   = ACC_W - QFRAC;

   // configuration port
   localparam int CSR_IDX_W = 4;

   // cycles after a register write until the matrix registers hold the new rotation
   localparam int SETTLE_W = 2;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(2);

   typedef logic signed [Q_W-1:0]       quat_type;
   typedef logic signed [QP_W-1:0]      qprod_type;
   typedef logic signed [M_W-1:0]       mat_entry_type;
   typedef mat_entry_type [2:0]         mat_row_type;
   typedef mat_row_type [2:0]           mat_type;
   typedef logic signed [VEC_WIDTH-1:0] vec_type;
   typedef vec_type [2:0]               vec3_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUAT_W = CSR_IDX_W'(0),
      CSR_QUAT_X = CSR_IDX_W'(1),
      CSR_QUAT_Y = CSR_IDX_W'(2),
      CSR_QUAT_Z = CSR_IDX_W'(3)
   } csr_index_type;

   localparam quat_type QUAT_ONE = Q_W'(1) << QFRAC;
   localparam logic signed [2*Q_W-1:0] QP_RND = (2*Q_W)'(1) << (QFRAC - 1);
   localparam mat_entry_type M_HALF = M_W'(1) << (QFRAC - 1);
   localparam logic signed [LO_W-1:0] LO_RND = LO_W'(1) << (QFRAC - 1);

   localparam vec_type VEC_MAX = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
   localparam vec_type VEC_MIN = {1'b1, {(VEC_WIDTH - 1){1'b0}}};

   // Q1.30 product, round to nearest with ties up
   function automatic qprod_type qprod(input quat_type a, input quat_type b);
      logic signed [2*Q_W-1:0] p;
      p = a * b;
      p = p + QP_RND;
      return QP_W'(p >>> QFRAC);
   endfunction

endpackage

// ===== hw/rtl/qvr_matrix.sv =====
`timescale 1ns / 1ps
// quaternion registers and the two-stage rotation matrix build
module qvr_matrix (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [qvr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [qvr_pkg::Q_W-1:0]        csr_wdata,
   output qvr_pkg::mat_type               mat,
   output logic                           mat_ready
);

   qvr_pkg::quat_type quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;
   qvr_pkg::qprod_type xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   qvr_pkg::mat_type mat_in, mat_ff;
   logic [qvr_pkg::SETTLE_W-1:0] settle_ff, settle_in;
   logic csr_xfer;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_w_ff <= qvr_pkg::QUAT_ONE;
         quat_x_ff <= '0;
         quat_y_ff <= '0;
         quat_z_ff <= '0;
      end else if (csr_xfer) begin
         unique case (csr_index)
            qvr_pkg::CSR_QUAT_W: quat_w_ff <= csr_wdata;
            qvr_pkg::CSR_QUAT_X: quat_x_ff <= csr_wdata;
            qvr_pkg::CSR_QUAT_Y: quat_y_ff <= csr_wdata;
            qvr_pkg::CSR_QUAT_Z: quat_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage one: the nine rounded quaternion products
   always_ff @(posedge clock) begin
      xx_ff <= qvr_pkg::qprod(quat_x_ff, quat_x_ff);
      yy_ff <= qvr_pkg::qprod(quat_y_ff, quat_y_ff);
      zz_ff <= qvr_pkg::qprod(quat_z_ff, quat_z_ff);
      xy_ff <= qvr_pkg::qprod(quat_x_ff, quat_y_ff);
      xz_ff <= qvr_pkg::qprod(quat_x_ff, quat_z_ff);
      yz_ff <= qvr_pkg::qprod(quat_y_ff, quat_z_ff);
      wx_ff <= qvr_pkg::qprod(quat_w_ff, quat_x_ff);
      wy_ff <= qvr_pkg::qprod(quat_w_ff, quat_y_ff);
      wz_ff <= qvr_pkg::qprod(quat_w_ff, quat_z_ff);
   end

   // stage two: matrix entries, doubled
   always_comb begin
      mat_in[0][0] = (qvr_pkg::M_HALF - qvr_pkg::M_W'(yy_ff) - qvr_pkg::M_W'(zz_ff)) <<< 1;
      mat_in[0][1] = (qvr_pkg::M_W'(xy_ff) - qvr_pkg::M_W'(wz_ff)) <<< 1;
      mat_in[0][2] = (qvr_pkg::M_W'(xz_ff) + qvr_pkg::M_W'(wy_ff)) <<< 1;
      mat_in[1][0] = (qvr_pkg::M_W'(xy_ff) + qvr_pkg::M_W'(wz_ff)) <<< 1;
      mat_in[1][1] = (qvr_pkg::M_HALF - qvr_pkg::M_W'(xx_ff) - qvr_pkg::M_W'(zz_ff)) <<< 1;
      mat_in[1][2] = (qvr_pkg::M_W'(yz_ff) - qvr_pkg::M_W'(wx_ff)) <<< 1;
      mat_in[2][0] = (qvr_pkg::M_W'(xz_ff) - qvr_pkg::M_W'(wy_ff)) <<< 1;
      mat_in[2][1] = (qvr_pkg::M_W'(yz_ff) + qvr_pkg::M_W'(wx_ff)) <<< 1;
      mat_in[2][2] = (qvr_pkg::M_HALF - qvr_pkg::M_W'(xx_ff) - qvr_pkg::M_W'(yy_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
   end

   assign mat = mat_ff;

   // hold off vectors until a new quaternion has reached the matrix registers
   always_comb begin
      settle_in = settle_ff;
      if (csr_xfer) begin
         settle_in = qvr_pkg::SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - qvr_pkg::SETTLE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= qvr_pkg::SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
      end
   end

   assign mat_ready = (settle_ff == '0);

endmodule

// ===== hw/rtl/qvr_row.sv =====
`timescale 1ns / 1ps
// one matrix row dotted with the vector: products, sums, rounding, clip
module qvr_row (
   input  logic                   clock,
   input  logic                   en,
   input  qvr_pkg::mat_row_type   m_row,
   input  qvr_pkg::vec3_type      vec,
   output qvr_pkg::vec_type       rot,
   output logic                   sat
);

   logic signed [qvr_pkg::VH_W-1:0] vh [3];
   logic        [qvr_pkg::VL_W-1:0] vl [3];
   logic signed [qvr_pkg::PH_W-1:0] ph_in [3];
   logic signed [qvr_pkg::PH_W-1:0] ph_ff [3];
   logic signed [qvr_pkg::PL_W-1:0] pl_in [3];
   logic signed [qvr_pkg::PL_W-1:0] pl_ff [3];
   logic signed [qvr_pkg::HI_W-1:0] hi_in, hi_ff;
   logic signed [qvr_pkg::LO_W-1:0] lo_in, lo_ff;
   logic signed [qvr_pkg::ACC_W-1:0] tot;
   logic signed [qvr_pkg::R_W-1:0] r_in, r_ff;
   logic pos_ovf, neg_ovf;

   // split each component so no multiplier sees the whole vector width
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vh[k]    = $signed(vec[k][qvr_pkg::VEC_WIDTH-1:qvr_pkg::VL_W]);
         vl[k]    = vec[k][qvr_pkg::VL_W-1:0];
         ph_in[k] = $signed(m_row[k]) * vh[k];
         pl_in[k] = $signed(m_row[k]) * $signed({1'b0, vl[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
      end
   end

   always_comb begin
      hi_in = qvr_pkg::HI_W'(ph_ff[0]) + qvr_pkg::HI_W'(ph_ff[1])
            + qvr_pkg::HI_W'(ph_ff[2]);
      lo_in = qvr_pkg::LO_W'(pl_ff[0]) + qvr_pkg::LO_W'(pl_ff[1])
            + qvr_pkg::LO_W'(pl_ff[2]) + qvr_pkg::LO_RND;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   // recombine the halves and drop the fraction bits
   always_comb begin
      tot  = (qvr_pkg::ACC_W'(hi_ff) <<< qvr_pkg::VL_W) + qvr_pkg::ACC_W'(lo_ff);
      r_in = qvr_pkg::R_W'(tot >>> qvr_pkg::QFRAC);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
      end
   end

   // clip to the vector range
   always_comb begin
      pos_ovf = !r_ff[qvr_pkg::R_W-1] && (|r_ff[qvr_pkg::R_W-2:qvr_pkg::VEC_WIDTH-1]);
      neg_ovf = r_ff[qvr_pkg::R_W-1] && !(&r_ff[qvr_pkg::R_W-2:qvr_pkg::VEC_WIDTH-1]);
      priority if (pos_ovf) begin
         rot = qvr_pkg::VEC_MAX;
      end else if (neg_ovf) begin
         rot = qvr_pkg::VEC_MIN;
      end else begin
         rot = r_ff[qvr_pkg::VEC_WIDTH-1:0];
      end
      sat = pos_ovf || neg_ovf;
   end

endmodule

// ===== hw/rtl/quaternion_vector_rotate.sv =====
`timescale 1ns / 1ps
// register stages: four (products, sums, rounded result, output); a stall holds them all
// throughput: one vector per cycle from the pipelined rows unless stalled or settling
// a register write holds off new vectors while the matrix is rebuilt
// reset: synchronous, clears the pipeline valid bits and loads the identity quaternion
// after reset, vectors are also held off while the matrix settles
module quaternion_vector_rotate (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  qvr_pkg::vec_type               req_vec_x,
   input  qvr_pkg::vec_type               req_vec_y,
   input  qvr_pkg::vec_type               req_vec_z,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output qvr_pkg::vec_type               rsp_rot_x,
   output qvr_pkg::vec_type               rsp_rot_y,
   output qvr_pkg::vec_type               rsp_rot_z,
   output logic                           rsp_saturated,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [qvr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [qvr_pkg::Q_W-1:0]        csr_wdata
);

   qvr_pkg::mat_type  mat;
   logic              mat_ready;
   qvr_pkg::vec3_type vec_in;
   qvr_pkg::vec3_type row_rot;
   logic [2:0]        row_sat;
   logic              adv;
   logic [2:0]        vld_ff;
   logic              rsp_valid_ff;
   qvr_pkg::vec3_type rot_ff;
   logic              sat_ff;

   qvr_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mat       (mat),
      .mat_ready (mat_ready)
   );

   assign vec_in = {req_vec_z, req_vec_y, req_vec_x};

   // whole pipeline moves whenever the output slot is free or being drained
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && mat_ready;

   for (genvar g = 0; g < 3; g++) begin : g_row
      qvr_row u_row (
         .clock (clock),
         .en    (adv),
         .m_row (mat[g]),
         .vec   (vec_in),
         .rot   (row_rot[g]),
         .sat   (row_sat[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[1:0], req_valid && req_ready};
         rsp_valid_ff <= vld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rot_ff <= row_rot;
         sat_ff <= |row_sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rot_x     = rot_ff[0];
   assign rsp_rot_y     = rot_ff[1];
   assign rsp_rot_z     = rot_ff[2];
   assign rsp_saturated = sat_ff;

   // a quaternion write must keep vectors out until the matrix is rebuilt
   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("vector taken while matrix settles");

   // a stalled result stalls the whole pipe
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("vector taken while output is stalled");

   // saturation flag only with a component at a range limit
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_rot_x == qvr_pkg::VEC_MAX || rsp_rot_x == qvr_pkg::VEC_MIN ||
          rsp_rot_y == qvr_pkg::VEC_MAX || rsp_rot_y == qvr_pkg::VEC_MIN ||
          rsp_rot_z == qvr_pkg::VEC_MAX || rsp_rot_z == qvr_pkg::VEC_MIN))
      else $error("saturated set with no component clipped");

endmodule
